// ----- src/ryuv_pkg.sv -----
package ryuv_pkg;

    localparam int FRAME_MAX_W = 4096;
    localparam int FRAME_MAX_H = 4096;
    localparam int LINE_DEPTH  = FRAME_MAX_W / 2;
    localparam int LINE_AW     = $clog2(LINE_DEPTH);
    localparam int COL_W       = $clog2(FRAME_MAX_W);
    localparam int ROW_W       = $clog2(FRAME_MAX_H);
    localparam int SIZE_W      = 13;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);

    localparam logic [SIZE_W-1:0] MAX_W_EVEN = SIZE_W'(FRAME_MAX_W & ~1);
    localparam logic [SIZE_W-1:0] MAX_H_EVEN = SIZE_W'(FRAME_MAX_H & ~1);

    localparam logic [2:0] FMT_RGB888   = 3'd0;
    localparam logic [2:0] FMT_BGR888   = 3'd1;
    localparam logic [2:0] FMT_RGBA8888 = 3'd2;
    localparam logic [2:0] FMT_BGRA8888 = 3'd3;
    localparam logic [2:0] FMT_GRAY8    = 3'd4;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_LEVEL  = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

    // q0.16 coefficients
    localparam logic [15:0] K_Y_R   = 16'd19595;
    localparam logic [15:0] K_Y_G   = 16'd38470;
    localparam logic [15:0] K_Y_B   = 16'd7471;
    localparam logic [15:0] K_CB_R  = 16'd11076;
    localparam logic [15:0] K_CB_G  = 16'd21692;
    localparam logic [15:0] K_HALF  = 16'd32768;
    localparam logic [15:0] K_CR_G  = 16'd27460;
    localparam logic [15:0] K_CR_B  = 16'd5308;
    localparam logic [15:0] K_Y_STU = 16'd56284;
    localparam logic [15:0] K_C_STU = 16'd57569;

    localparam logic [7:0] CHROMA_MID = 8'd128;

    typedef struct packed {
        logic [2:0]        format;
        logic              level;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       gray;
        logic       level;
        logic       cvalid;
        logic       eor;
        logic       eof;
        logic [9:0] rs;
        logic [9:0] gs;
        logic [9:0] bs;
    } t_item;

endpackage

// ----- src/ryuv_front.sv -----
module ryuv_front
    import ryuv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_byte_zero,
    input  logic [7:0] i_byte_one,
    input  logic [7:0] i_byte_two,
    output logic       o_stall,
    output logic       o_push,
    output t_item      o_item,
    input  logic       i_full
);

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        gray;
        logic        level;
        logic        cvalid;
        logic        eor;
        logic        eof;
        logic [26:0] pair;
    } t_front;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] m);
        logic [SIZE_W-1:0] s;
        s = {v[SIZE_W-1:1], 1'b0};
        if (s > m) s = m;
        if (s < SIZE_W'(2)) s = SIZE_W'(2);
        return s;
    endfunction

    logic [26:0]       line_mem [LINE_DEPTH];
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [26:0]       r_pend, n_pend;
    logic              r_s1_valid, n_s1_valid;
    t_front            r_s1, n_s1;
    logic [26:0]       r_top;

    logic [SIZE_W-1:0] w, h;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [LINE_AW-1:0] idx;
    logic              gray, swap, accept, s1_free, eor, eof, wr_en;
    logic [7:0]        r, g, b;
    logic [26:0]       pix, pair;

    always_comb begin
        w = eff_size(i_cfg.width, MAX_W_EVEN);
        h = eff_size(i_cfg.height, MAX_H_EVEN);
        x = ({1'b0, r_col} >= w) ? COL_W'(w - SIZE_W'(1)) : r_col;
        y = ({1'b0, r_row} >= h) ? ROW_W'(h - SIZE_W'(1)) : r_row;
        idx = x[COL_W-1:1];
        gray = (i_cfg.format == FMT_GRAY8);
        swap = (i_cfg.format == FMT_BGR888) || (i_cfg.format == FMT_BGRA8888);
        if (gray) begin
            r = i_byte_zero;
            g = i_byte_zero;
            b = i_byte_zero;
        end else if (swap) begin
            r = i_byte_two;
            g = i_byte_one;
            b = i_byte_zero;
        end else begin
            r = i_byte_zero;
            g = i_byte_one;
            b = i_byte_two;
        end
        pix  = {1'b0, b, 1'b0, g, 1'b0, r};
        pair = r_pend + pix;
        eor  = ({1'b0, x} + SIZE_W'(1)) >= w;
        eof  = eor && (({1'b0, y} + SIZE_W'(1)) >= h);

        s1_free = !r_s1_valid || !i_full;
        accept  = i_valid && s1_free;
        wr_en   = accept && x[0] && !y[0];

        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        if (accept) begin
            n_pend = x[0] ? pair : pix;
            if (eor) begin
                n_col = '0;
                n_row = eof ? '0 : ROW_W'(y + ROW_W'(1));
            end else begin
                n_col = COL_W'(x + COL_W'(1));
                n_row = y;
            end
        end

        n_s1.r      = r;
        n_s1.g      = g;
        n_s1.b      = b;
        n_s1.gray   = gray;
        n_s1.level  = i_cfg.level;
        n_s1.cvalid = x[0] && y[0];
        n_s1.eor    = eor;
        n_s1.eof    = eof;
        n_s1.pair   = pair;

        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (o_push) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_pend     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_pend     <= n_pend;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1  <= n_s1;
            r_top <= line_mem[idx];
        end
        if (wr_en) begin
            line_mem[idx] <= pair;
        end
    end

    assign o_stall = !s1_free;
    assign o_push  = r_s1_valid && !i_full;

    always_comb begin
        o_item.r      = r_s1.r;
        o_item.g      = r_s1.g;
        o_item.b      = r_s1.b;
        o_item.gray   = r_s1.gray;
        o_item.level  = r_s1.level;
        o_item.cvalid = r_s1.cvalid;
        o_item.eor    = r_s1.eor;
        o_item.eof    = r_s1.eof;
        o_item.rs     = {1'b0, r_top[8:0]}   + {1'b0, r_s1.pair[8:0]};
        o_item.gs     = {1'b0, r_top[17:9]}  + {1'b0, r_s1.pair[17:9]};
        o_item.bs     = {1'b0, r_top[26:18]} + {1'b0, r_s1.pair[26:18]};
    end

endmodule

// ----- src/ryuv_queue.sv -----
module ryuv_queue
    import ryuv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QAW:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = i_push ? QAW'(r_wr + QAW'(1)) : r_wr;
        n_rd  = i_pop  ? QAW'(r_rd + QAW'(1)) : r_rd;
        n_cnt = r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

// ----- src/ryuv_back.sv -----
module ryuv_back
    import ryuv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_luma,
    output logic       o_chroma_valid,
    output logic [7:0] o_blue_diff,
    output logic [7:0] o_red_diff,
    output logic       o_end_of_row,
    output logic       o_end_of_frame
);

    typedef struct packed {
        logic [7:0] r;
        logic       gray;
        logic       level;
        logic       cvalid;
        logic       eor;
        logic       eof;
    } t_ctl;

    function automatic logic [7:0] sat8(input logic [12:0] v);
        return (v > 13'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] chroma_full(input logic signed [27:0] t);
        logic signed [28:0] tot;
        tot = 29'(t) + 29'sd33554432 + 29'sd131072;
        if (tot < 0) return 8'd0;
        return sat8({2'b00, tot[28:18]});
    endfunction

    function automatic logic [7:0] chroma_studio(input logic signed [45:0] tm);
        logic signed [46:0] tot;
        tot = 47'(tm) + (47'sd1 <<< 41) + (47'sd1 <<< 33);
        if (tot < 0) return 8'd0;
        return sat8(tot[46:34]);
    endfunction

    logic en;

    // stage a: products
    logic        r_a_valid;
    t_ctl        r_a_ctl;
    logic [23:0] r_yr, r_yg, r_yb;
    logic [25:0] r_cb_r, r_cb_g, r_cb_b, r_cr_r, r_cr_g, r_cr_b;

    // stage b: sums
    logic               r_b_valid;
    t_ctl               r_b_ctl;
    logic [23:0]        r_yq;
    logic signed [27:0] r_tb, r_tr;

    // stage c: studio scaling
    logic               r_c_valid;
    t_ctl               r_c_ctl;
    logic [23:0]        r_c_yq;
    logic signed [27:0] r_c_tb, r_c_tr;
    logic [39:0]        r_yqm;
    logic signed [45:0] r_tbm, r_trm;

    // output register
    logic       r_o_valid;
    logic [7:0] r_luma, r_cb, r_cr;
    logic       r_cv, r_eor, r_eof;

    logic [7:0]  n_luma, n_cb, n_cr;
    logic [24:0] y_full;
    logic [41:0] y_stu;
    t_ctl        in_ctl;

    assign en    = !(r_o_valid && i_stall);
    assign o_pop = en && !i_empty;

    always_comb begin
        in_ctl.r      = i_item.r;
        in_ctl.gray   = i_item.gray;
        in_ctl.level  = i_item.level;
        in_ctl.cvalid = i_item.cvalid;
        in_ctl.eor    = i_item.eor;
        in_ctl.eof    = i_item.eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= !i_empty;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctl <= in_ctl;
            r_yr    <= 24'(K_Y_R) * 24'(i_item.r);
            r_yg    <= 24'(K_Y_G) * 24'(i_item.g);
            r_yb    <= 24'(K_Y_B) * 24'(i_item.b);
            r_cb_r  <= 26'(K_CB_R) * 26'(i_item.rs);
            r_cb_g  <= 26'(K_CB_G) * 26'(i_item.gs);
            r_cb_b  <= 26'(K_HALF) * 26'(i_item.bs);
            r_cr_r  <= 26'(K_HALF) * 26'(i_item.rs);
            r_cr_g  <= 26'(K_CR_G) * 26'(i_item.gs);
            r_cr_b  <= 26'(K_CR_B) * 26'(i_item.bs);

            r_b_ctl <= r_a_ctl;
            r_yq    <= r_yr + r_yg + r_yb;
            r_tb    <= signed'(28'(r_cb_b)) - signed'(28'(r_cb_r)) - signed'(28'(r_cb_g));
            r_tr    <= signed'(28'(r_cr_r)) - signed'(28'(r_cr_g)) - signed'(28'(r_cr_b));

            r_c_ctl <= r_b_ctl;
            r_c_yq  <= r_yq;
            r_c_tb  <= r_tb;
            r_c_tr  <= r_tr;
            r_yqm   <= 40'(r_yq) * 40'(K_Y_STU);
            r_tbm   <= 46'(r_tb) * signed'(46'(K_C_STU));
            r_trm   <= 46'(r_tr) * signed'(46'(K_C_STU));

            r_luma  <= n_luma;
            r_cb    <= n_cb;
            r_cr    <= n_cr;
            r_cv    <= r_c_ctl.cvalid;
            r_eor   <= r_c_ctl.eor;
            r_eof   <= r_c_ctl.eof;
        end
    end

    always_comb begin
        y_full = 25'(r_c_yq) + 25'd32768;
        y_stu  = 42'(r_yqm) + (42'd16 << 32) + (42'd1 << 31);
        if (r_c_ctl.gray) begin
            n_luma = r_c_ctl.r;
        end else if (r_c_ctl.level) begin
            n_luma = sat8({3'b000, y_stu[41:32]});
        end else begin
            n_luma = sat8({4'b0000, y_full[24:16]});
        end

        if (!r_c_ctl.cvalid) begin
            n_cb = 8'd0;
            n_cr = 8'd0;
        end else if (r_c_ctl.gray) begin
            n_cb = CHROMA_MID;
            n_cr = CHROMA_MID;
        end else if (r_c_ctl.level) begin
            n_cb = chroma_studio(r_tbm);
            n_cr = chroma_studio(r_trm);
        end else begin
            n_cb = chroma_full(r_c_tb);
            n_cr = chroma_full(r_c_tr);
        end
    end

    assign o_valid        = r_o_valid;
    assign o_luma         = r_luma;
    assign o_chroma_valid = r_cv;
    assign o_blue_diff    = r_cb;
    assign o_red_diff     = r_cr;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_cv) |-> (r_cb == 8'd0 && r_cr == 8'd0))
        else $error("chroma set without a closed block");

    a_frame_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_eof) |-> r_eor)
        else $error("end of frame without end of row");

endmodule

// ----- src/rgb_to_yuv420_encoder.sv -----
// rgb to yuv 4:2:0 converter, bt.601 coefficients
// input channel: one packed pixel per transaction (i_valid / o_stall), raster order;
// the configured format picks the r, g, b bytes or a gray byte, alpha is ignored
// output channel: one result per pixel (o_valid / i_stall) with luma, end of row
// and end of frame flags; on every odd row, odd column pixel chroma_valid is set
// and blue_diff / red_diff carry the 2x2 block average, otherwise they read zero
// throughput: one pixel per cycle sustained while the receiver does not stall; a result
// passes one front register, the queue, three multiply and sum stages and the output
// register
// a 2048 x 27 line buffer holds pair sums of each even row; one read and one
// write port, read data registered
// a receiver stall freezes the back pipeline and holds the output; the queue
// then fills and o_stall rises, so no transaction is lost
// reset clears the row and column counters, the pipeline and the queue and sets
// the registers to rgb888, full range, 640 x 480; no clearing pass is needed
// registers (apb, 32 bit): 0x0 format, 0x4 level range, 0x8 width, 0xc height
module rgb_to_yuv420_encoder
    import ryuv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_zero,
    input  logic [7:0]  i_byte_one,
    input  logic [7:0]  i_byte_two,
    input  logic [7:0]  i_byte_three,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_luma,
    output logic        o_chroma_valid,
    output logic [7:0]  o_blue_diff,
    output logic [7:0]  o_red_diff,
    output logic        o_end_of_row,
    output logic        o_end_of_frame
);

    t_cfg  r_cfg;
    logic  wr;
    logic  push, full, pop, empty;
    t_item f_item, q_item;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.format <= FMT_RGB888;
            r_cfg.level  <= 1'b0;
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_FORMAT: r_cfg.format <= pwdata[2:0];
                REG_LEVEL:  r_cfg.level  <= pwdata[0];
                REG_WIDTH:  r_cfg.width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_cfg.height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FORMAT: prdata = {29'd0, r_cfg.format};
            REG_LEVEL:  prdata = {31'd0, r_cfg.level};
            REG_WIDTH:  prdata = {19'd0, r_cfg.width};
            REG_HEIGHT: prdata = {19'd0, r_cfg.height};
            default:    prdata = 32'd0;
        endcase
    end

    ryuv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .i_byte_zero (i_byte_zero),
        .i_byte_one  (i_byte_one),
        .i_byte_two  (i_byte_two),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (f_item),
        .i_full      (full)
    );

    ryuv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (empty)
    );

    ryuv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (q_item),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_blue_diff    (o_blue_diff),
        .o_red_diff     (o_red_diff),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ryuv_pkg::*;

    localparam int N_PIX       = 1650;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } pix_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       cvalid;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       eor;
        logic       eof;
    } yuv_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_byte_zero;
    logic [7:0]  i_byte_one;
    logic [7:0]  i_byte_two;
    logic [7:0]  i_byte_three;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_luma;
    logic        o_chroma_valid;
    logic [7:0]  o_blue_diff;
    logic [7:0]  o_red_diff;
    logic        o_end_of_row;
    logic        o_end_of_frame;

    rgb_to_yuv420_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_zero    (i_byte_zero),
        .i_byte_one     (i_byte_one),
        .i_byte_two     (i_byte_two),
        .i_byte_three   (i_byte_three),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_blue_diff    (o_blue_diff),
        .o_red_diff     (o_red_diff),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    // shadow of the register file
    logic [2:0]  fmt_cfg    = FMT_RGB888;
    bit          studio_cfg = 1'b0;
    logic [12:0] width_cfg  = WIDTH_RST;
    logic [12:0] height_cfg = HEIGHT_RST;

    // converter state
    int          col_pos   = 0;
    int          row_pos   = 0;
    logic [26:0] half_pair = '0;
    logic [26:0] top_pairs [LINE_DEPTH];
    bit          lb_written [LINE_DEPTH];

    pix_t pix_q [$];
    yuv_t yuv_q [$];
    pix_t nxt_pix;
    yuv_t got_yuv;
    yuv_t want_yuv;

    bit px_taken     = 1'b0;
    int pix_sent     = 0;
    int pix_accepted = 0;
    int pix_total    = 0;
    int mism_cnt     = 0;
    int cycle_cnt    = 0;
    int src_idle_pct = 16;
    int snk_idle_pct = 16;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clip_size(input logic [12:0] v, input int maxv);
        int s;
        s = int'(v) & ~1;
        if (s > (maxv & ~1)) s = maxv & ~1;
        if (s < 2) s = 2;
        return s;
    endfunction

    function automatic logic [7:0] chroma_code(input longint t, input bit studio);
        longint acc;
        longint q;
        int sh;
        if (studio) begin
            acc = (longint'(128) << 34) + t * longint'(K_C_STU);
            sh = 34;
        end else begin
            acc = (longint'(128) << 18) + t;
            sh = 18;
        end
        if (acc < 0) return 8'd0;
        q = (acc + (longint'(1) << (sh - 1))) >>> sh;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    task automatic convert_pixel(input pix_t p);
        int w, h, x, y, idx;
        logic [7:0] r, g, b;
        logic [63:0] yq, lq;
        logic [26:0] pix, pair, top;
        longint rs, gs, bs;
        bit is_gray, is_swap;
        yuv_t e;
        w = clip_size(width_cfg, FRAME_MAX_W);
        h = clip_size(height_cfg, FRAME_MAX_H);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        is_gray = (fmt_cfg == FMT_GRAY8);
        is_swap = (fmt_cfg == FMT_BGR888) || (fmt_cfg == FMT_BGRA8888);
        e = '0;
        if (is_gray) begin
            r = p.b0; g = p.b0; b = p.b0;
        end else if (is_swap) begin
            r = p.b2; g = p.b1; b = p.b0;
        end else begin
            r = p.b0; g = p.b1; b = p.b2;
        end
        if (is_gray) begin
            e.luma = p.b0;
        end else begin
            yq = K_Y_R * r + K_Y_G * g + K_Y_B * b;
            if (studio_cfg)
                lq = (yq * K_Y_STU + (64'd16 << 32) + (64'd1 << 31)) >> 32;
            else
                lq = (yq + 64'd32768) >> 16;
            e.luma = (lq > 255) ? 8'd255 : lq[7:0];
        end
        pix = 27'(r) | (27'(g) << 9) | (27'(b) << 18);
        idx = x >> 1;
        if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
        if ((x & 1) == 0) begin
            half_pair = pix;
        end else begin
            pair = half_pair + pix;
            if ((y & 1) == 0) begin
                top_pairs[idx] = pair;
                lb_written[idx] = 1'b1;
            end else begin
                top = top_pairs[idx];
                rs = longint'(top[8:0]) + longint'(pair[8:0]);
                gs = longint'(top[17:9]) + longint'(pair[17:9]);
                bs = longint'(top[26:18]) + longint'(pair[26:18]);
                e.cvalid = 1'b1;
                if (is_gray) begin
                    e.cb = CHROMA_MID;
                    e.cr = CHROMA_MID;
                end else begin
                    e.cb = chroma_code(-longint'(K_CB_R) * rs - longint'(K_CB_G) * gs
                                       + longint'(K_HALF) * bs, studio_cfg);
                    e.cr = chroma_code(longint'(K_HALF) * rs - longint'(K_CR_G) * gs
                                       - longint'(K_CR_B) * bs, studio_cfg);
                end
            end
            half_pair = pair;
        end
        e.eor = (x + 1 >= w);
        e.eof = e.eor && (y + 1 >= h);
        if (e.eor) begin
            col_pos = 0;
            row_pos = e.eof ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
        yuv_q.push_back(e);
    endtask

    // an odd row must never read a line buffer entry that was never written
    function automatic bit line_ok(input int wn, input int hn);
        int y;
        y = (row_pos >= hn) ? hn - 1 : row_pos;
        if ((y & 1) == 0) return 1'b1;
        for (int i = 0; i < wn / 2; i++)
            if (!lb_written[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int frame_left();
        int w, h, x, y;
        w = clip_size(width_cfg, FRAME_MAX_W);
        h = clip_size(height_cfg, FRAME_MAX_H);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        return (h - 1 - y) * w + (w - x);
    endfunction

    function automatic logic [12:0] pick_size();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 13'($urandom_range(0, 1));
        if (k == 1) return 13'($urandom_range(4097, 8191));
        if (k == 2) return 13'd4096;
        if (k < 6) return 13'($urandom_range(1, 7) * 2 + 1);
        return 13'($urandom_range(1, 6) * 2);
    endfunction

    function automatic logic [7:0] rand_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 8'h00;
        if (k == 1) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FORMAT: fmt_cfg = val[2:0];
            REG_LEVEL:  studio_cfg = val[0];
            REG_WIDTH:  width_cfg = val[12:0];
            REG_HEIGHT: height_cfg = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [2:0] fmt, input bit lvl,
                             input logic [12:0] w, input logic [12:0] h);
        reg_write(REG_FORMAT, 32'(fmt));
        reg_write(REG_LEVEL, 32'(lvl));
        reg_write(REG_WIDTH, 32'(w));
        reg_write(REG_HEIGHT, 32'(h));
    endtask

    task automatic push_px(input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d);
        pix_q.push_back({a, b, c, d});
        pix_total++;
    endtask

    task automatic push_rand(input int n);
        for (int i = 0; i < n; i++)
            push_px(rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic drain();
        while (pix_q.size() != 0 || pix_sent != pix_accepted || yuv_q.size() != 0)
            @(posedge i_clk);
    endtask

    // source side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || px_taken) begin
            if (pix_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt_pix = pix_q.pop_front();
                i_byte_zero  <= nxt_pix.b0;
                i_byte_one   <= nxt_pix.b1;
                i_byte_two   <= nxt_pix.b2;
                i_byte_three <= nxt_pix.b3;
                i_valid      <= 1'b1;
                pix_sent++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // sink side, with one long hold-off once a big batch is queued
    always @(negedge i_clk) begin
        if (hold_left == 0 && !hold_done && pix_q.size() >= 100) begin
            hold_left = 150;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < snk_idle_pct);
        end
    end

    // accepted pixels feed the prediction, delivered results are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            px_taken = 1'b0;
        end else begin
            px_taken = i_valid && !o_stall;
            if (px_taken) begin
                convert_pixel({i_byte_zero, i_byte_one, i_byte_two, i_byte_three});
                pix_accepted++;
            end
            if (o_valid && !i_stall) begin
                got_yuv = {o_luma, o_chroma_valid, o_blue_diff, o_red_diff,
                           o_end_of_row, o_end_of_frame};
                if (yuv_q.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("unexpected transaction: luma %0d cv %0b cb %0d cr %0d eor %0b eof %0b",
                                 got_yuv.luma, got_yuv.cvalid, got_yuv.cb, got_yuv.cr,
                                 got_yuv.eor, got_yuv.eof);
                end else begin
                    want_yuv = yuv_q.pop_front();
                    if (got_yuv.luma !== want_yuv.luma || got_yuv.cvalid !== want_yuv.cvalid ||
                        got_yuv.cb !== want_yuv.cb || got_yuv.cr !== want_yuv.cr ||
                        got_yuv.eor !== want_yuv.eor || got_yuv.eof !== want_yuv.eof) begin
                        mism_cnt++;
                        if (mism_cnt <= 10)
                            $display("mismatch: want luma %0d cv %0b cb %0d cr %0d eor %0b eof %0b, got luma %0d cv %0b cb %0d cr %0d eor %0b eof %0b",
                                     want_yuv.luma, want_yuv.cvalid, want_yuv.cb, want_yuv.cr,
                                     want_yuv.eor, want_yuv.eof, got_yuv.luma, got_yuv.cvalid,
                                     got_yuv.cb, got_yuv.cr, got_yuv.eor, got_yuv.eof);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stim
        logic [12:0] nw;
        logic [12:0] nh;
        int left;
        bit burst_done;
        burst_done   = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_byte_zero  = '0;
        i_byte_one   = '0;
        i_byte_two   = '0;
        i_byte_three = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // black, white, primaries; the red block saturates cr
        set_frame(FMT_RGB888, 1'b0, 13'd4, 13'd2);
        push_px(8'h00, 8'h00, 8'h00, 8'h00);
        push_px(8'hff, 8'hff, 8'hff, 8'hff);
        push_px(8'hff, 8'h00, 8'h00, 8'h00);
        push_px(8'hff, 8'h00, 8'h00, 8'hff);
        push_px(8'h00, 8'hff, 8'h00, 8'haa);
        push_px(8'h00, 8'h00, 8'hff, 8'h55);
        push_px(8'hff, 8'h00, 8'h00, 8'h00);
        push_px(8'hff, 8'h00, 8'h00, 8'h00);
        drain();

        // sizes of zero and one act as two, studio swing
        set_frame(FMT_BGRA8888, 1'b1, 13'd0, 13'd1);
        push_px(8'hff, 8'h00, 8'h00, 8'h00);
        push_px(8'hff, 8'hff, 8'hff, 8'h00);
        push_px(8'h00, 8'h00, 8'h00, 8'hff);
        push_px(8'hff, 8'h00, 8'h00, 8'h00);
        drain();

        // gray source, odd sizes lose their low bit
        set_frame(FMT_GRAY8, 1'b1, 13'd3, 13'd3);
        push_px(8'h00, 8'h12, 8'h34, 8'h56);
        push_px(8'hff, 8'h00, 8'h00, 8'h00);
        push_px(8'h11, 8'hc8, 8'h03, 8'h09);
        push_px(8'h80, 8'hff, 8'hff, 8'hff);
        drain();

        // unknown format code behaves as rgb888
        set_frame(3'd7, 1'b0, 13'd2, 13'd2);
        push_px(8'h00, 8'hff, 8'h00, 8'h00);
        push_px(8'h00, 8'hff, 8'h00, 8'hff);
        push_px(8'hff, 8'hff, 8'h00, 8'h00);
        push_px(8'h00, 8'h00, 8'hff, 8'h00);
        drain();

        set_frame(FMT_BGR888, 1'b1, 13'd2, 13'd2);
        push_px(8'h00, 8'h00, 8'hff, 8'h00);
        push_px(8'hff, 8'h00, 8'hff, 8'h00);
        push_px(8'h00, 8'hff, 8'hff, 8'h00);
        push_px(8'h7f, 8'h80, 8'h01, 8'hfe);
        drain();

        // saturated sizes, then shrink so the counters sit past the end
        set_frame(FMT_RGBA8888, 1'b0, 13'd8191, 13'd8191);
        push_rand(100);
        drain();
        reg_write(REG_WIDTH, 32'd6);
        reg_write(REG_HEIGHT, 32'd5);
        push_rand(30);
        drain();
        reg_write(REG_HEIGHT, 32'd8191);
        push_rand(60);
        drain();
        reg_write(REG_HEIGHT, 32'd4);
        push_rand(20);
        drain();

        while (pix_total < N_PIX) begin
            if ($urandom_range(0, 1)) reg_write(REG_FORMAT, 32'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0) reg_write(REG_LEVEL, 32'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0 || frame_left() > 400) begin
                nw = pick_size();
                nh = $urandom_range(0, 1) ? pick_size() : height_cfg;
                if (line_ok(clip_size(nw, FRAME_MAX_W), clip_size(nh, FRAME_MAX_H))) begin
                    reg_write(REG_WIDTH, 32'(nw));
                    reg_write(REG_HEIGHT, 32'(nh));
                end
            end
            if (!burst_done && pix_total >= 700) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
                push_rand(240);
                burst_done = 1'b1;
            end else begin
                left = frame_left();
                push_rand((left <= 64 && $urandom_range(0, 3) != 0) ? left
                                                                    : $urandom_range(1, 48));
            end
            drain();
            src_idle_pct = 16;
            snk_idle_pct = 16;
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mism_cnt == 0 && yuv_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
src/ryuv_pkg.sv
src/ryuv_front.sv
src/ryuv_queue.sv
src/ryuv_back.sv
src/rgb_to_yuv420_encoder.sv
bench/tb.sv
